// ===== sv/alle_pkg.sv =====
// Shared constants and types for the array linked list engine.
// No dependencies; every other file in the project but alle_ram imports this package.
package alle_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int LINK_W      = $clog2(MAX_ENTRIES + 1);

  // Field widths of the request and result beats.
  localparam int CMD_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  // A link equal to the table size marks the end of the list.
  localparam logic [LINK_W-1:0] END_LINK = LINK_W'(MAX_ENTRIES);
  localparam logic [LINK_W-1:0] MAX_CNT  = LINK_W'(MAX_ENTRIES);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic             any;
    logic [IDX_W-1:0] slot;
  } free_t;

endpackage

// ===== sv/alle_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// Depends on alle_pkg for the field widths.
interface alle_in_if import alle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink (input valid, cmd, value, output ready);
endinterface

interface alle_out_if import alle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, slot_index, entry_count, input ready);
  modport sink (input valid, status, slot_index, entry_count, output ready);
endinterface

// ===== sv/alle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module alle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/alle_free_find.sv =====
// Priority encoder that finds the lowest-numbered free slot.
// Depends on alle_pkg for the table size and the free_t result type.
module alle_free_find import alle_pkg::*; (
  input  logic [MAX_ENTRIES-1:0] used,
  output free_t                  free
);

  always_comb begin
    free.any  = 1'b0;
    free.slot = '0;
    // Scanning from the top down leaves the lowest free slot in place.
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free.any  = 1'b1;
        free.slot = IDX_W'(i);
      end
    end
  end

endmodule

// ===== sv/array_linked_list_engine_top.sv =====
// Array linked list engine: a singly linked list kept in a table of slots.
// Depends on alle_pkg, alle_if, alle_ram and alle_free_find.
//
// Usage:
//   in_ch carries request beats (cmd, value): insert at tail, search, or
//   delete first match. out_ch carries one result beat per request
//   (status, slot_index, entry_count).
//   Values and links sit in two RAMs with a registered read port. A
//   search or delete walks one list node per cycle, since the link read
//   from the RAM is fed straight back as the next read address.
//   An insert into an empty list, a failed insert, an unknown command, or a
//   search or delete on an empty list goes from S_EXEC straight to S_RESP;
//   an insert behind an existing tail first passes S_LINK to relink the
//   tail; a search or delete walks in S_WALK, examining at most MAX_ENTRIES
//   nodes. One request is in flight at a time, so the next request beat
//   is not taken while an operation runs; it is taken at the earliest
//   the cycle after the result enters the output register. All RAM writes
//   of an operation are done before its result is formed, ahead of the next
//   request's first read, so no forwarding is needed.
//   Reset clears every used bit, empties the list and drops any pending
//   result; no clearing pass is required. If the receiver stalls, the
//   result stays in the output register while the next request is
//   processed; that request then waits for the register to free up.
module array_linked_list_engine_top import alle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  alle_in_if.sink     in_ch,
  alle_out_if.source  out_ch
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WALK = 5'b00100,
    S_LINK = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [MAX_ENTRIES-1:0]  used_r, used_nxt;
  logic [LINK_W-1:0]       head_r, head_nxt;
  logic [LINK_W-1:0]       tail_r, tail_nxt;
  logic [LINK_W-1:0]       length_r, length_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [VAL_W-1:0]        val_r, val_nxt;
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic [LINK_W-1:0]       prev_r, prev_nxt;
  logic [IDX_W-1:0]        steps_r, steps_nxt;
  logic [IDX_W-1:0]        ins_r, ins_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [IDX_W-1:0]        res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0]      out_count_r, out_count_nxt;

  logic                    val_we;
  logic [IDX_W-1:0]        val_waddr;
  logic [VAL_W-1:0]        val_wdata;
  logic [VAL_W-1:0]        val_rdata;
  logic                    link_we;
  logic [IDX_W-1:0]        link_waddr;
  logic [LINK_W-1:0]       link_wdata;
  logic [LINK_W-1:0]       link_rdata;
  logic [IDX_W-1:0]        raddr;
  free_t                   free;
  logic                    hit;

  alle_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  alle_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (raddr),
    .rdata (link_rdata)
  );

  alle_free_find u_free_find (
    .used (used_r),
    .free (free)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot_index  = out_slot_r;
  assign out_ch.entry_count = out_count_r;

  // During a walk the RAM data belongs to cur_r.
  assign hit = used_r[cur_r] && (val_rdata == val_r);

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    length_nxt     = length_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    steps_nxt      = steps_r;
    ins_nxt        = ins_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    val_we         = 1'b0;
    val_waddr      = free.slot;
    val_wdata      = val_r;
    link_we        = 1'b0;
    link_waddr     = free.slot;
    link_wdata     = END_LINK;
    raddr          = head_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          val_nxt   = in_ch.value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (length_r >= MAX_CNT || !free.any) begin
              res_status_nxt = ST_FULL;
              res_slot_nxt   = '0;
              state_nxt      = S_RESP;
            end else begin
              val_we             = 1'b1;
              link_we            = 1'b1;
              used_nxt[free.slot] = 1'b1;
              length_nxt         = length_r + 1'b1;
              if (head_r == END_LINK) begin
                head_nxt       = LINK_W'(free.slot);
                tail_nxt       = LINK_W'(free.slot);
                res_status_nxt = ST_OK;
                res_slot_nxt   = free.slot;
                state_nxt      = S_RESP;
              end else begin
                ins_nxt   = free.slot;
                state_nxt = S_LINK;
              end
            end
          end
          CMD_SEARCH, CMD_DELETE: begin
            if (head_r == END_LINK) begin
              res_status_nxt = ST_NOT_FOUND;
              res_slot_nxt   = '0;
              state_nxt      = S_RESP;
            end else begin
              cur_nxt   = head_r[IDX_W-1:0];
              prev_nxt  = END_LINK;
              steps_nxt = '0;
              state_nxt = S_WALK;
            end
          end
          default: begin
            res_status_nxt = ST_OK;
            res_slot_nxt   = '0;
            state_nxt      = S_RESP;
          end
        endcase
      end
      S_LINK: begin
        link_we        = 1'b1;
        link_waddr     = tail_r[IDX_W-1:0];
        link_wdata     = LINK_W'(ins_r);
        tail_nxt       = LINK_W'(ins_r);
        res_status_nxt = ST_OK;
        res_slot_nxt   = ins_r;
        state_nxt      = S_RESP;
      end
      S_WALK: begin
        raddr = link_rdata[IDX_W-1:0];
        if (hit) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
          if (cmd_r == CMD_SEARCH) begin
            res_slot_nxt = cur_r;
          end else begin
            res_slot_nxt = '0;
            // Unlink: the predecessor, or the head, takes over our link.
            if (prev_r == END_LINK) begin
              head_nxt = link_rdata;
            end else begin
              link_we    = 1'b1;
              link_waddr = prev_r[IDX_W-1:0];
              link_wdata = link_rdata;
            end
            used_nxt[cur_r] = 1'b0;
            if (length_r != '0) begin
              length_nxt = length_r - 1'b1;
            end
            if (tail_r == LINK_W'(cur_r)) begin
              tail_nxt = prev_r;
            end
          end
        end else if (link_rdata >= END_LINK || steps_r == IDX_W'(MAX_ENTRIES - 1)) begin
          res_status_nxt = ST_NOT_FOUND;
          res_slot_nxt   = '0;
          state_nxt      = S_RESP;
        end else begin
          prev_nxt  = LINK_W'(cur_r);
          cur_nxt   = link_rdata[IDX_W-1:0];
          steps_nxt = steps_r + 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = SLOT_W'(res_slot_r);
          out_count_nxt  = COUNT_W'(length_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      head_r      <= END_LINK;
      tail_r      <= END_LINK;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    steps_r      <= steps_nxt;
    ins_r        <= ins_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

`ifndef ASSERT_OFF
  a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == 32'(length_r))
    else $error("list length disagrees with the number of used slots");

  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == END_LINK) == (length_r == '0))
    else $error("head pointer and list length disagree on emptiness");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= MAX_CNT)
    else $error("list length exceeds the table size");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_EXEC)
    else $error("accepted request did not start execution");

  a_resp_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP && (!out_valid_r || out_ch.ready) |=> out_valid_r)
    else $error("finished result did not reach the output register");
`endif

endmodule

// ===== tb/array_linked_list_engine_top_tb.sv =====
// Self-checking testbench for array_linked_list_engine_top: directed and random
// insert, search, delete and unknown-command requests with random idling on both channels.
// Depends on alle_pkg, the alle_in_if / alle_out_if channel interfaces and the engine top.
module array_linked_list_engine_top_tb import alle_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_NOP      = 2'd3;
  localparam logic [VAL_W-1:0] OLD_SENTINEL = -32'sd9999;
  localparam int               MAX_GAP      = 12;
  localparam int               RANDOM_REQS  = 1800;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } result_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  // Tracks the list contents and queues the result each accepted request must produce.
  class ListScoreboard;
    logic [VAL_W-1:0] slot_val  [MAX_ENTRIES];
    int unsigned      next_slot [MAX_ENTRIES];
    bit               slot_busy [MAX_ENTRIES];
    int unsigned      head;
    int unsigned      length;
    result_t          pending_q[$];
    int unsigned      errors, checked;
    int unsigned      n_insert, n_full, n_hit, n_miss, n_unlink, n_nop;

    function new();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_val[i]  = '0;
        next_slot[i] = MAX_ENTRIES;
        slot_busy[i] = 1'b0;
      end
      head   = MAX_ENTRIES;
      length = 0;
    endfunction

    // First entry from the head holding v, or MAX_ENTRIES; prev_slot gets its predecessor.
    function int unsigned find_first(input logic [VAL_W-1:0] v, output int unsigned prev_slot);
      int unsigned cur, prev, steps;
      cur = head;
      prev = MAX_ENTRIES;
      steps = 0;
      prev_slot = MAX_ENTRIES;
      while (cur < MAX_ENTRIES && steps < MAX_ENTRIES) begin
        if (slot_busy[cur] && slot_val[cur] == v) begin
          prev_slot = prev;
          return cur;
        end
        prev = cur;
        cur = next_slot[cur];
        steps++;
      end
      return MAX_ENTRIES;
    endfunction

    function void note_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] v);
      result_t     r;
      int unsigned s, prev, cur, steps;
      r.status = ST_OK;
      r.slot = '0;
      case (cmd)
        CMD_INSERT: begin
          s = MAX_ENTRIES;
          for (int i = MAX_ENTRIES - 1; i >= 0; i--)
            if (!slot_busy[i]) s = i;
          if (length >= MAX_ENTRIES || s >= MAX_ENTRIES) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            slot_val[s] = v;
            next_slot[s] = MAX_ENTRIES;
            slot_busy[s] = 1'b1;
            if (head >= MAX_ENTRIES) begin
              head = s;
            end else begin
              cur = head;
              steps = 0;
              while (next_slot[cur] < MAX_ENTRIES && steps < MAX_ENTRIES) begin
                cur = next_slot[cur];
                steps++;
              end
              next_slot[cur] = s;
            end
            length++;
            r.slot = SLOT_W'(s);
            n_insert++;
          end
        end
        CMD_SEARCH: begin
          s = find_first(v, prev);
          if (s >= MAX_ENTRIES) begin
            r.status = ST_NOT_FOUND;
            n_miss++;
          end else begin
            r.slot = SLOT_W'(s);
            n_hit++;
          end
        end
        CMD_DELETE: begin
          s = find_first(v, prev);
          if (s >= MAX_ENTRIES) begin
            r.status = ST_NOT_FOUND;
            n_miss++;
          end else begin
            if (prev >= MAX_ENTRIES) head = next_slot[s];
            else next_slot[prev] = next_slot[s];
            slot_busy[s] = 1'b0;
            next_slot[s] = MAX_ENTRIES;
            if (length > 0) length--;
            n_unlink++;
          end
        end
        default: n_nop++;
      endcase
      r.count = COUNT_W'(length);
      pending_q.push_back(r);
    endfunction

    // A value currently in the list (a random one when it is empty), so that searches and deletes can hit.
    function logic [VAL_W-1:0] stored_value();
      int unsigned pick, seen;
      if (length == 0) return $urandom;
      pick = $urandom_range(0, length - 1);
      seen = 0;
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_busy[i]) begin
          if (seen == pick) return slot_val[i];
          seen++;
        end
      return $urandom;
    endfunction

    task report(input string what, input int got, input int want);
      $display("[%0t] mismatch on %0s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(input result_t got);
      result_t want;
      checked++;
      if (pending_q.size() == 0) begin
        report("result beat with nothing pending", got.status, -1);
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.slot !== want.slot) report("slot_index", got.slot, want.slot);
        if (got.count !== want.count) report("entry_count", got.count, want.count);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  alle_in_if  in_ch ();
  alle_out_if out_ch ();

  array_linked_list_engine_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ListScoreboard sb;
  bit            req_burst;
  bit            rsp_burst;
  logic [VAL_W-1:0] pool [8];

  always #6 clk = ~clk;

  initial begin
    #20ms;
    $display("timeout with %0d results still pending", sb.pending_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Present one request beat after a random gap (none in a burst) and hold it until it is taken.
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] v);
    int gap;
    gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= v;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_request(cmd, v);
  endtask

  function automatic logic [VAL_W-1:0] draw_value(input bit lookup);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (lookup && r < 50) return sb.stored_value();
    if (r < 80) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.status, out_ch.slot_index, out_ch.entry_count});
  end

  // Result side: random stalls before each beat, with stall-free stretches.
  initial begin
    int stall;
    int beats;
    out_ch.ready = 1'b0;
    rsp_burst = 1'b0;
    beats = 0;
    @(posedge rst_n);
    forever begin
      if (beats % 50 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      stall = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      beats++;
    end
  end

  initial begin
    mix_t        mix;
    int unsigned r;
    logic [CMD_W-1:0] cmd;

    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_INSERT;
    in_ch.value = '0;
    req_burst = 1'b0;
    mix = MIX_EVEN;
    sb = new();
    pool = '{OLD_SENTINEL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
             $urandom, $urandom, $urandom};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty list, the old sentinel as data, extremes, duplicates,
    // unlinking at head, middle and tail, then a full table.
    send_req(CMD_SEARCH, 32'h0);
    send_req(CMD_DELETE, 32'h5);
    send_req(CMD_INSERT, OLD_SENTINEL);
    send_req(CMD_SEARCH, OLD_SENTINEL);
    send_req(CMD_INSERT, 32'h8000_0000);
    send_req(CMD_INSERT, 32'h7FFF_FFFF);
    send_req(CMD_INSERT, 32'hFFFF_FFFF);
    send_req(CMD_INSERT, OLD_SENTINEL);
    send_req(CMD_SEARCH, OLD_SENTINEL);
    send_req(CMD_DELETE, 32'h8000_0000);
    send_req(CMD_INSERT, 32'd42);
    send_req(CMD_DELETE, OLD_SENTINEL);
    send_req(CMD_DELETE, 32'd42);
    while (sb.length < MAX_ENTRIES) send_req(CMD_INSERT, $urandom);
    send_req(CMD_INSERT, 32'h0);
    send_req(CMD_NOP, 32'hFFFF_FFFF);
    send_req(CMD_SEARCH, 32'hFFFF_FFFF);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 100 == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        req_burst = ($urandom_range(0, 3) == 0);
        pool[$urandom_range(5, 7)] = $urandom;
        pool[$urandom_range(0, 7)] = $urandom;
      end
      r = $urandom_range(0, 99);
      case (mix)
        MIX_GROW:   cmd = (r < 60) ? CMD_INSERT : (r < 80) ? CMD_SEARCH :
                          (r < 95) ? CMD_DELETE : CMD_NOP;
        MIX_SHRINK: cmd = (r < 20) ? CMD_INSERT : (r < 45) ? CMD_SEARCH :
                          (r < 95) ? CMD_DELETE : CMD_NOP;
        default:    cmd = (r < 35) ? CMD_INSERT : (r < 65) ? CMD_SEARCH :
                          (r < 95) ? CMD_DELETE : CMD_NOP;
      endcase
      send_req(cmd, draw_value(cmd == CMD_SEARCH || cmd == CMD_DELETE));
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (MAX_ENTRIES + 8) @(posedge clk);

    $display("%0d results checked: %0d inserts, %0d table-full, %0d found, %0d unlinked,",
             sb.checked, sb.n_insert, sb.n_full, sb.n_hit, sb.n_unlink);
    $display("%0d not found, %0d unknown commands; %0d mismatches",
             sb.n_miss, sb.n_nop, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
